### sv/s2cd_pkg.sv
// s2cd_pkg: field types, calendar constants and helpers for the seconds to calendar date block
// no dependencies; compiled first

package s2cd_pkg;

   typedef logic [31:0] seconds_type;
   typedef logic [5:0]  sixty_type;
   typedef logic [4:0]  hour_type;
   typedef logic [4:0]  mday_type;
   typedef logic [3:0]  month_type;
   typedef logic [7:0]  year_type;
   typedef logic [2:0]  weekday_type;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

   localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
   localparam year_type    CENTURY_OFFSET = 8'd100;   // 2100, not a leap year
   localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;
   localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd5;     // 2000-01-01 was a saturday

   localparam month_type   MONTH_FEB  = 4'd1;        // zero based month codes
   localparam month_type   MONTH_JUL  = 4'd6;
   localparam month_type   MONTH_LAST = 4'd11;

   // gregorian leap rule over offsets 0..199 from 2000
   function automatic logic is_leap(input year_type offset);
      is_leap = (offset[1:0] == 2'b00) && (offset != CENTURY_OFFSET);
   endfunction

   // length of a zero based month
   function automatic mday_type month_days(input logic leap, input month_type month);
      month_type m;
      m = month;
      if (month == MONTH_FEB) begin
         month_days = leap ? 5'd29 : 5'd28;
      end else begin
         if (month > MONTH_JUL) begin
            m = month - 4'd1;
         end
         month_days = m[0] ? 5'd30 : 5'd31;
      end
   endfunction

endpackage

### sv/s2cd_req_if.sv
// s2cd_req_if: request channel carrying one seconds count per item
// depends on s2cd_pkg

interface s2cd_req_if;
   import s2cd_pkg::*;

   logic        valid;
   logic        ready;
   seconds_type seconds_count;

   modport source (output valid, output seconds_count, input ready);
   modport sink   (input valid, input seconds_count, output ready);
endinterface

### sv/s2cd_rsp_if.sv
// s2cd_rsp_if: response channel carrying one calendar date and time per item
// depends on s2cd_pkg

interface s2cd_rsp_if;
   import s2cd_pkg::*;

   logic        valid;
   logic        ready;
   sixty_type   second_of_minute;
   sixty_type   minute_of_hour;
   hour_type    hour_of_day;
   mday_type    day_of_month;
   month_type   month_number;
   year_type    year_offset;
   weekday_type weekday_number;

   modport source (output valid, output second_of_minute, output minute_of_hour,
                   output hour_of_day, output day_of_month, output month_number,
                   output year_offset, output weekday_number, input ready);
   modport sink   (input valid, input second_of_minute, input minute_of_hour,
                   input hour_of_day, input day_of_month, input month_number,
                   input year_offset, input weekday_number, output ready);
endinterface

### sv/seconds_to_calendar_date_top.sv
// seconds_to_calendar_date_top: seconds since 2000-01-01 00:00:00 to date, time and weekday
// depends on s2cd_pkg, s2cd_req_if, s2cd_rsp_if
//
// channel    dir  handshake            payload
// req_chan   in   valid / ready        seconds_count (32b)
// rsp_chan   out  valid / ready        second, minute, hour, day, month, year offset, weekday
//
// one item in the sequencer; req_chan.ready is high only while the sequencer is idle
// an item runs the day, hour, minute, year and month phases, then the finish step;
// the phase steps all go through the single 18-bit subtractor
// day division is restoring, one quotient bit per cycle; weekday residue rides along
// reset (synchronous, active high) empties the sequencer and the result register
// a stalled result holds in the output register; the next item is accepted meanwhile
// and waits in the finish step only if the output register is still full

module seconds_to_calendar_date_top (
   input logic clock,
   input logic reset,
   s2cd_req_if.sink   req_chan,
   s2cd_rsp_if.source rsp_chan
);
   import s2cd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAYS,
      ST_HOURS,
      ST_MINUTES,
      ST_YEARS,
      ST_MONTHS,
      ST_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;          // step counter inside a phase
   seconds_type num_ff, num_in;          // dividend, shifted out msb first
   logic [16:0] tod_ff, tod_in;          // seconds of the day, reduced in place
   logic [15:0] days_ff, days_in;        // whole days, then days left in the year
   logic [2:0]  wday_ff, wday_in;        // whole days mod 7
   hour_type    hour_ff, hour_in;
   sixty_type   minute_ff, minute_in;
   year_type    year_ff, year_in;
   month_type   month_ff, month_in;      // zero based

   // result register
   logic        out_valid_ff;
   sixty_type   out_sec_ff;
   sixty_type   out_min_ff;
   hour_type    out_hour_ff;
   mday_type    out_day_ff;
   month_type   out_month_ff;
   year_type    out_year_ff;
   weekday_type out_wday_ff;

   // shared subtract / compare unit
   logic [17:0] op_a, op_b;
   logic [18:0] diff;
   logic        borrow;

   logic [17:0] partial;                 // next partial remainder of the day division
   logic [3:0]  wday_step;
   logic [3:0]  wday_sum;
   weekday_type weekday;
   logic        leap;
   logic        out_free;
   logic        load_out;

   assign partial   = {tod_ff, num_ff[31]};
   assign leap      = is_leap(year_ff);
   assign diff      = {1'b0, op_a} - {1'b0, op_b};
   assign borrow    = diff[18];
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign load_out  = (state_ff == ST_FINISH) && out_free;

   // (days mod 7 + 5) mod 7
   assign wday_sum  = {1'b0, wday_ff} + {1'b0, EPOCH_WEEKDAY};
   assign weekday   = (wday_sum >= {1'b0, DAYS_PER_WEEK}) ?
                      3'(wday_sum - {1'b0, DAYS_PER_WEEK}) : wday_sum[2:0];

   // residue of the day quotient tracked bit by bit
   assign wday_step = {wday_ff, !borrow};

   // operand select for the shared unit
   always_comb begin
      op_a = partial;
      op_b = {1'b0, SECS_PER_DAY};
      case (state_ff)
         ST_DAYS: begin
            op_a = partial;
            op_b = {1'b0, SECS_PER_DAY};
         end
         ST_HOURS: begin
            op_a = {1'b0, tod_ff};
            op_b = {6'd0, SECS_PER_HOUR} << cnt_ff[2:0];
         end
         ST_MINUTES: begin
            op_a = {1'b0, tod_ff};
            op_b = {12'd0, SECS_PER_MIN} << cnt_ff[2:0];
         end
         ST_YEARS: begin
            op_a = {2'd0, days_ff};
            op_b = 18'(DAYS_PER_YEAR) + 18'(leap);
         end
         ST_MONTHS: begin
            op_a = {2'd0, days_ff};
            op_b = 18'(month_days(leap, month_ff));
         end
         default: begin
            op_a = partial;
            op_b = {1'b0, SECS_PER_DAY};
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      tod_in    = tod_ff;
      days_in   = days_ff;
      wday_in   = wday_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               num_in   = req_chan.seconds_count;
               tod_in   = '0;
               days_in  = '0;
               wday_in  = '0;
               year_in  = '0;
               month_in = '0;
               cnt_in   = 5'd31;
               state_in = ST_DAYS;
            end
         end
         ST_DAYS: begin
            // restoring division by the day length
            tod_in  = borrow ? partial[16:0] : diff[16:0];
            days_in = {days_ff[14:0], !borrow};
            wday_in = (wday_step >= {1'b0, DAYS_PER_WEEK}) ?
                      3'(wday_step - {1'b0, DAYS_PER_WEEK}) : wday_step[2:0];
            num_in  = {num_ff[30:0], 1'b0};
            if (cnt_ff == 5'd0) begin
               cnt_in   = 5'd4;
               state_in = ST_HOURS;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_HOURS: begin
            if (!borrow) begin
               tod_in = diff[16:0];
            end
            hour_in = {hour_ff[3:0], !borrow};
            if (cnt_ff == 5'd0) begin
               cnt_in   = 5'd5;
               state_in = ST_MINUTES;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_MINUTES: begin
            if (!borrow) begin
               tod_in = diff[16:0];
            end
            minute_in = {minute_ff[4:0], !borrow};
            if (cnt_ff == 5'd0) begin
               state_in = ST_YEARS;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_YEARS: begin
            if (borrow) begin
               state_in = ST_MONTHS;
            end else begin
               days_in = diff[15:0];
               year_in = year_ff + 8'd1;
            end
         end
         ST_MONTHS: begin
            if (borrow || (month_ff == MONTH_LAST)) begin
               state_in = ST_FINISH;
            end else begin
               days_in  = diff[15:0];
               month_in = month_ff + 4'd1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         num_ff    <= num_in;
         tod_ff    <= tod_in;
         days_ff   <= days_in;
         wday_ff   <= wday_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
            out_sec_ff   <= tod_ff[5:0];
            out_min_ff   <= minute_ff;
            out_hour_ff  <= hour_ff;
            out_day_ff   <= days_ff[4:0] + 5'd1;
            out_month_ff <= month_ff + 4'd1;
            out_year_ff  <= year_ff;
            out_wday_ff  <= weekday;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.second_of_minute = out_sec_ff;
   assign rsp_chan.minute_of_hour   = out_min_ff;
   assign rsp_chan.hour_of_day      = out_hour_ff;
   assign rsp_chan.day_of_month     = out_day_ff;
   assign rsp_chan.month_number     = out_month_ff;
   assign rsp_chan.year_offset      = out_year_ff;
   assign rsp_chan.weekday_number   = out_wday_ff;

   // an accepted item always starts the day division
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_DAYS) && (cnt_ff == 5'd31))
      else $error("accepted item did not start the day division");

   // the year walk never runs past the last reachable year
   a_year_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEARS) |-> (year_ff <= 8'd136))
      else $error("year offset out of range");

   // a loaded result carries a time of day and month in range
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_chan.valid && (rsp_chan.hour_of_day <= 5'd23) &&
                   (rsp_chan.minute_of_hour <= 6'd59) &&
                   (rsp_chan.second_of_minute <= 6'd59) &&
                   (rsp_chan.month_number != 4'd0) && (rsp_chan.month_number <= 4'd12))
      else $error("result field out of range");

   // no new item while a result waits for the output register
   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && !out_free) |=> (state_ff == ST_FINISH))
      else $error("finish step left while output register full");

endmodule

### sim/seconds_to_calendar_date_top_tb.sv
// seconds_to_calendar_date_top_tb: self-checking bench for the seconds to calendar date block
// drives epoch second counts, predicts date, time and weekday, and compares every result item
// depends on s2cd_pkg, s2cd_req_if, s2cd_rsp_if and seconds_to_calendar_date_top

module seconds_to_calendar_date_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import s2cd_pkg::*;

   // run shape
   localparam int unsigned RANDOM_ITEMS   = 830;
   localparam int unsigned MAX_GAP        = 8;
   localparam int unsigned HOLD_AT_ITEM   = 250;    // item count that starts the long stall
   localparam int unsigned HOLD_CYCLES    = 1500;   // long result-side stall
   localparam int unsigned DRAIN_CYCLES   = 200;    // settle time after the last result item
   localparam int unsigned WATCHDOG_LIMIT = 10000;  // cycles with no handshake on either side
   localparam int unsigned LAST_DAY       = 49710;  // last day whose start fits in 32 bits

   localparam int unsigned DAY_SECONDS    = 86400;
   localparam int unsigned HOUR_SECONDS   = 3600;
   localparam int unsigned MINUTE_SECONDS = 60;

   // day counts from 2000-01-01 for the calendar corners
   localparam int unsigned DAY_2000_FEB29 = 59;
   localparam int unsigned DAY_2000_MAR01 = 60;
   localparam int unsigned DAY_2001_JAN01 = 366;
   localparam int unsigned DAY_2100_JAN01 = 36525;
   localparam int unsigned DAY_2100_FEB28 = 36583;
   localparam int unsigned DAY_2100_MAR01 = 36584;
   localparam int unsigned DAY_2101_JAN01 = 36890;

   // expected date and time of one item, with the seconds it came from
   typedef struct packed {
      seconds_type source_seconds;
      sixty_type   second_of_minute;
      sixty_type   minute_of_hour;
      hour_type    hour_of_day;
      mday_type    day_of_month;
      month_type   month_number;
      year_type    year_offset;
      weekday_type weekday_number;
   } date_time_type;

   // non-leap month lengths, january first
   localparam int unsigned MONTH_LENGTHS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   logic clock = 1'b0;
   logic reset = 1'b1;

   s2cd_req_if req_chan ();
   s2cd_rsp_if rsp_chan ();

   seconds_type   pending_seconds [$];   // items not yet offered
   date_time_type expected_dates  [$];   // predictions waiting for their result item

   int unsigned accepted_count = 0;    // items taken by the block
   int unsigned offered_count  = 0;
   int unsigned received_count = 0;    // result items taken from the block
   int unsigned mismatches     = 0;
   int unsigned send_gap       = 0;
   int unsigned recv_stall     = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 1'b0;
   int unsigned idle_cycles    = 0;

   seconds_to_calendar_date_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // full gregorian rule on the calendar year, not on the offset
   function automatic bit gregorian_leap(input int unsigned offset);
      int unsigned y;
      y = 2000 + offset;
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // date, time and weekday for a count of seconds since 2000-01-01 00:00:00
   function automatic date_time_type calendar_of(input seconds_type secs);
      int unsigned   tod;
      int unsigned   days;
      int unsigned   left;
      int unsigned   yr;
      int unsigned   mon;
      int unsigned   span;
      bit            leap;
      date_time_type d;
      tod  = secs % DAY_SECONDS;
      days = secs / DAY_SECONDS;
      left = days;
      yr   = 0;
      // peel off whole years
      while (1) begin
         span = gregorian_leap(yr) ? 366 : 365;
         if (left < span) break;
         left -= span;
         yr++;
      end
      // then whole months, december takes whatever is left
      leap = gregorian_leap(yr);
      mon  = 0;
      while (mon < 11) begin
         span = MONTH_LENGTHS[mon] + ((mon == 1 && leap) ? 1 : 0);
         if (left < span) break;
         left -= span;
         mon++;
      end
      d.source_seconds   = secs;
      d.second_of_minute = sixty_type'(tod % MINUTE_SECONDS);
      d.minute_of_hour   = sixty_type'((tod % HOUR_SECONDS) / MINUTE_SECONDS);
      d.hour_of_day      = hour_type'(tod / HOUR_SECONDS);
      d.day_of_month     = mday_type'(left + 1);
      d.month_number     = month_type'(mon + 1);
      d.year_offset      = year_type'(yr);
      d.weekday_number   = weekday_type'(((days % 7) + 5) % 7);  // epoch was a saturday
      return d;
   endfunction

   // one line per mismatch
   task automatic report_mismatch(input string what, input seconds_type secs,
                                  input int unsigned got, input int unsigned want);
      $display("%0t: %s wrong for seconds %0d: got %0d, want %0d",
               $realtime, what, secs, got, want);
      mismatches++;
   endtask

   // sender: offers pending items, waits a drawn gap before each next one
   // every 80 items it runs 20 back to back
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid         <= 1'b0;
         req_chan.seconds_count <= '0;
         send_gap               <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_dates.push_back(calendar_of(req_chan.seconds_count));
            accepted_count <= accepted_count + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap       <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_seconds.size() > 0) begin
               req_chan.valid         <= 1'b1;
               req_chan.seconds_count <= pending_seconds.pop_front();
               offered_count          <= offered_count + 1;
               send_gap               <= (offered_count % 80 < 20) ? 0
                                         : $urandom_range(0, MAX_GAP);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result item against the oldest prediction,
   // then stalls a drawn number of cycles; every 70 items it runs 15 without stalls
   always @(posedge clock) begin
      int unsigned   next_stall;
      date_time_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall     <= 0;
      end else begin
         next_stall = (recv_stall > 0) ? recv_stall - 1 : 0;
         if (rsp_chan.valid && rsp_chan.ready) begin
            received_count <= received_count + 1;
            if (expected_dates.size() == 0) begin
               report_mismatch("result with no item pending", '0, 0, 0);
            end else begin
               want = expected_dates.pop_front();
               if (rsp_chan.second_of_minute !== want.second_of_minute)
                  report_mismatch("second", want.source_seconds,
                                  rsp_chan.second_of_minute, want.second_of_minute);
               if (rsp_chan.minute_of_hour !== want.minute_of_hour)
                  report_mismatch("minute", want.source_seconds,
                                  rsp_chan.minute_of_hour, want.minute_of_hour);
               if (rsp_chan.hour_of_day !== want.hour_of_day)
                  report_mismatch("hour", want.source_seconds,
                                  rsp_chan.hour_of_day, want.hour_of_day);
               if (rsp_chan.day_of_month !== want.day_of_month)
                  report_mismatch("day", want.source_seconds,
                                  rsp_chan.day_of_month, want.day_of_month);
               if (rsp_chan.month_number !== want.month_number)
                  report_mismatch("month", want.source_seconds,
                                  rsp_chan.month_number, want.month_number);
               if (rsp_chan.year_offset !== want.year_offset)
                  report_mismatch("year offset", want.source_seconds,
                                  rsp_chan.year_offset, want.year_offset);
               if (rsp_chan.weekday_number !== want.weekday_number)
                  report_mismatch("weekday", want.source_seconds,
                                  rsp_chan.weekday_number, want.weekday_number);
            end
            next_stall = (received_count % 70 < 15) ? 0 : $urandom_range(0, MAX_GAP);
         end
         recv_stall     <= next_stall;
         rsp_chan.ready <= (next_stall == 0) && (hold_left == 0);
      end
   end

   // long receiver hold-off: the output register fills, the next item is taken
   // and parks, and the request side must then stall while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT_ITEM) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // watchdog: any handshake on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("seconds_to_calendar_date_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus, reset and end of run
   initial begin
      longint unsigned candidate;
      int unsigned     day;
      int unsigned     shape;

      // directed: field extremes, rollovers, leap day of 2000, the 2100 century rule
      pending_seconds.push_back(32'd0);
      pending_seconds.push_back(32'd1);
      pending_seconds.push_back(32'd59);
      pending_seconds.push_back(32'd60);
      pending_seconds.push_back(32'd3599);
      pending_seconds.push_back(32'd3600);
      pending_seconds.push_back(32'd86399);
      pending_seconds.push_back(32'd86400);
      pending_seconds.push_back(32'(DAY_2000_FEB29 * DAY_SECONDS));
      pending_seconds.push_back(32'(DAY_2000_MAR01 * DAY_SECONDS - 1));
      pending_seconds.push_back(32'(DAY_2000_MAR01 * DAY_SECONDS));
      pending_seconds.push_back(32'(DAY_2001_JAN01 * DAY_SECONDS - 1));
      pending_seconds.push_back(32'(DAY_2001_JAN01 * DAY_SECONDS));
      pending_seconds.push_back(32'(DAY_2100_JAN01 * DAY_SECONDS - 1));
      pending_seconds.push_back(32'(DAY_2100_JAN01 * DAY_SECONDS));
      pending_seconds.push_back(32'(DAY_2100_FEB28 * DAY_SECONDS + 86399));
      pending_seconds.push_back(32'(DAY_2100_MAR01 * DAY_SECONDS));
      pending_seconds.push_back(32'(DAY_2101_JAN01 * DAY_SECONDS - 1));
      pending_seconds.push_back(32'(DAY_2101_JAN01 * DAY_SECONDS));
      pending_seconds.push_back(32'hAAAA_AAAA);
      pending_seconds.push_back(32'h5555_5555);
      pending_seconds.push_back(32'hFFFF_FFFE);
      pending_seconds.push_back(32'hFFFF_FFFF);

      // random: raw counts, random day and time, midnight edges, early 2000
      repeat (RANDOM_ITEMS) begin
         shape = $urandom_range(0, 3);
         day   = $urandom_range(0, LAST_DAY);
         case (shape)
            0: candidate = $urandom;
            1: candidate = longint'(day) * DAY_SECONDS + $urandom_range(0, DAY_SECONDS - 1);
            2: candidate = longint'(day) * DAY_SECONDS
                           + ($urandom_range(0, 1) ? DAY_SECONDS - 1 : 0);
            default: candidate = $urandom_range(0, 32'h00FF_FFFF);
         endcase
         if (candidate > 64'hFFFF_FFFF) begin
            candidate = $urandom;   // day past the 32-bit end
         end
         pending_seconds.push_back(seconds_type'(candidate));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // all items taken and all results back, then let the block settle
      do @(negedge clock);
      while (!(pending_seconds.size() == 0 && !req_chan.valid && expected_dates.size() == 0));
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0) begin
         $display("seconds_to_calendar_date_top: match");
      end else begin
         $display("seconds_to_calendar_date_top: mismatch");
      end
      $finish;
   end

endmodule
